@@ rtl/cmg_pkg.sv @@
// Shared types, codes and trig tables for the cylinder mesh generator.
// Depends on nothing; every other file imports it.
package cmg_pkg;

   // Field widths fixed by the record formats
   localparam int CORNER_W = 5;
   localparam int RING_W   = 3;   // column index of the trig tables (8 columns)
   localparam int TAB_ROWS = 6;   // one row per segment count 3..8
   localparam int TAB_COLS = 8;

   // Record kinds
   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   // Normal selection codes
   localparam logic [1:0] NORM_SHELL = 2'd0;
   localparam logic [1:0] NORM_BOT   = 2'd1;
   localparam logic [1:0] NORM_TOP   = 2'd2;
   localparam logic [1:0] NORM_NONE  = 2'd3;

   // Cap normal z in Q2.14
   localparam logic signed [15:0] NORM_UNIT = 16'sd16384;

   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   // Ring cosine in Q1.30, row = segment count - 3
   localparam logic signed [31:0] COS_TAB [TAB_ROWS][TAB_COLS] = '{
      '{ONE_Q30, -32'sd536870912, -32'sd536870912, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{ONE_Q30, 32'sd0, -ONE_Q30, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{ONE_Q30, 32'sd331804471, -32'sd868675383, -32'sd868675383, 32'sd331804471,
        32'sd0, 32'sd0, 32'sd0},
      '{ONE_Q30, 32'sd536870912, -32'sd536870912, -ONE_Q30, -32'sd536870912,
        32'sd536870912, 32'sd0, 32'sd0},
      '{ONE_Q30, 32'sd669467077, -32'sd238930034, -32'sd967407956, -32'sd967407956,
        -32'sd238930034, 32'sd669467077, 32'sd0},
      '{ONE_Q30, 32'sd759250125, 32'sd0, -32'sd759250125, -ONE_Q30, -32'sd759250125,
        32'sd0, 32'sd759250125}
   };

   // Ring sine in Q1.30, row = segment count - 3
   localparam logic signed [31:0] SIN_TAB [TAB_ROWS][TAB_COLS] = '{
      '{32'sd0, 32'sd929887697, -32'sd929887697, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, ONE_Q30, 32'sd0, -ONE_Q30, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd1021189159, 32'sd631129609, -32'sd631129609, -32'sd1021189159,
        32'sd0, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd929887697, 32'sd929887697, 32'sd0, -32'sd929887697,
        -32'sd929887697, 32'sd0, 32'sd0},
      '{32'sd0, 32'sd839485162, 32'sd1046820875, 32'sd465879118, -32'sd465879118,
        -32'sd1046820875, -32'sd839485162, 32'sd0},
      '{32'sd0, 32'sd759250125, ONE_Q30, 32'sd759250125, 32'sd0, -32'sd759250125,
        -ONE_Q30, -32'sd759250125}
   };

   // Input transaction
   typedef struct packed {
      logic [31:0] cyl_radius;
      logic [31:0] cyl_height;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic                record_kind;
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic signed [15:0]  norm_x;
      logic signed [15:0]  norm_y;
      logic signed [15:0]  norm_z;
      logic [CORNER_W-1:0] corner_a;
      logic [CORNER_W-1:0] corner_b;
      logic [CORNER_W-1:0] corner_c;
      logic                last_record;
   } rsp_type;

   // Classified cylinder waiting for the back end
   typedef struct packed {
      logic [31:0] radius;
      logic [30:0] half_height;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   // Q1.30 to Q2.14, round half up
   function automatic logic signed [15:0] to_norm(input logic signed [31:0] c);
      logic signed [31:0] s;
      s = c + 32'sd32768;
      return s[31:16];
   endfunction

   // Q18.46 product to Q16.16, round half up, saturate
   function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
      logic signed [63:0] s;
      logic signed [33:0] v;
      s = p + 64'sd536870912;
      v = $signed(s[63:30]);
      if (v > 34'sd2147483647)
         return 32'sh7fffffff;
      else if (v < -34'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

endpackage

@@ rtl/cylinder_mesh_generator.sv @@
// Top level of the cylinder mesh generator: front end, job queue, back end.
// Depends on cmg_pkg, cmg_front, cmg_queue and cmg_back.
//
// Each accepted cylinder (start high while busy is low) yields 8*SEGMENTS-4
// records (SEGMENTS clamped to 3..8), 36 at the default of five segments:
// 2*SEGMENTS shell vertices, then the bottom and top cap vertices, then the shell
// triangles and the two cap fans. Records leave one per clock with rsp_valid high
// for that single cycle, and the receiver cannot stall them; last_record marks the
// final record of a cylinder. The back-end sequencer emits one record a cycle, and
// queued cylinders follow each other with no gap. With the back end idle, an
// accepted cylinder passes the holding register, queue, sequencer, multiply stage
// and output register before its first record is on the result ports. A two-entry
// queue plus an input holding register absorb up to three cylinders ahead of the
// one being emitted; busy rises only when all of them are full.
module cylinder_mesh_generator #(
   parameter int SEGMENTS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cmg_pkg::req_type req_data,
   output logic             rsp_valid,
   output cmg_pkg::rsp_type rsp_data
);
   import cmg_pkg::*;

   // Clamp the segment count to the table range
   localparam int SEG_N = (SEGMENTS < 3) ? 3 : ((SEGMENTS > 8) ? 8 : SEGMENTS);

   q_status_type q_status;
   job_type      push_job, head_job;
   logic         push, pop;

   cmg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   cmg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .status   (q_status),
      .head_job (head_job)
   );

   cmg_back #(
      .SEG_N (SEG_N)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/cmg_queue.sv @@
// Two-entry job queue between the front and back ends.
// Depends on cmg_pkg.
module cmg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cmg_pkg::job_type      push_job,
   input  logic                  pop,
   output cmg_pkg::q_status_type status,
   output cmg_pkg::job_type      head_job
);
   import cmg_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_job     = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/cmg_front.sv @@
// Front end: takes cylinder transactions and turns them into queue jobs.
// Depends on cmg_pkg.
module cmg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cmg_pkg::req_type      req_data,
   input  cmg_pkg::q_status_type q_status,
   output logic                  push,
   output cmg_pkg::job_type      push_job
);
   import cmg_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   job_type hold_job_ff;
   logic    accept;

   // Accept while the holding register can drain this cycle
   assign busy   = hold_valid_ff & q_status.full;
   assign accept = start & ~busy;
   assign push   = hold_valid_ff & ~q_status.full;

   always_comb begin
      hold_valid_in = accept | (hold_valid_ff & ~push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Classify: keep radius, halve height (truncated)
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_job_ff.radius      <= req_data.cyl_radius;
         hold_job_ff.half_height <= req_data.cyl_height[31:1];
      end
   end

   assign push_job = hold_job_ff;

endmodule

@@ rtl/cmg_back.sv @@
// Back end: record sequencer, position multipliers and output register.
// Depends on cmg_pkg.
module cmg_back #(
   parameter int SEG_N = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmg_pkg::q_status_type q_status,
   input  cmg_pkg::job_type      head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   output cmg_pkg::rsp_type      rsp_data
);
   import cmg_pkg::*;

   localparam int TAB_ROW = SEG_N - 3;
   localparam logic [RING_W-1:0]   LAST_IDX = RING_W'(SEG_N - 1);
   localparam logic [RING_W-1:0]   FAN_LAST = RING_W'(SEG_N - 2);
   localparam logic [CORNER_W-1:0] N5       = CORNER_W'(SEG_N);

   // Sequencer phases
   localparam logic [2:0] PH_SHELL = 3'd0;
   localparam logic [2:0] PH_BCAP  = 3'd1;
   localparam logic [2:0] PH_TCAP  = 3'd2;
   localparam logic [2:0] PH_SHTRI = 3'd3;
   localparam logic [2:0] PH_BFAN  = 3'd4;
   localparam logic [2:0] PH_TFAN  = 3'd5;

   // Sequencer state
   logic              active_ff, active_in;
   logic [2:0]        phase_ff, phase_in;
   logic [RING_W-1:0] idx_ff, idx_in;
   logic              sub_ff, sub_in;
   logic [31:0]       radius_ff;
   logic [30:0]       h2_ff;
   logic              seq_last;

   // Record descriptor of the current sequencer step
   logic                d_kind, d_top;
   logic [1:0]          d_nsel;
   logic [CORNER_W-1:0] d_ca, d_cb, d_cc;
   logic [CORNER_W-1:0] i5, j5;

   // Multiply stage
   logic signed [31:0] cos_sel, sin_sel;
   logic signed [32:0] r_s;
   logic signed [64:0] px_full, py_full;

   logic                b_valid_ff;
   logic                b_kind_ff, b_last_ff, b_top_ff;
   logic [CORNER_W-1:0] b_ca_ff, b_cb_ff, b_cc_ff;
   logic [30:0]         b_h2_ff;
   logic signed [63:0]  b_px_ff, b_py_ff;
   logic signed [15:0]  b_nx_ff, b_ny_ff, b_nz_ff;
   logic signed [15:0]  nx_in, ny_in, nz_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   assign seq_last = active_ff & (phase_ff == PH_TFAN) & (idx_ff == FAN_LAST);
   assign pop      = q_status.valid & (~active_ff | seq_last);

   // Advance the sequencer one record a cycle
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      sub_in    = sub_ff;
      if (pop) begin
         active_in = 1'b1;
         phase_in  = PH_SHELL;
         idx_in    = '0;
         sub_in    = 1'b0;
      end else if (seq_last) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         unique case (phase_ff)
            PH_SHELL, PH_SHTRI: begin
               if (!sub_ff) begin
                  sub_in = 1'b1;
               end else begin
                  sub_in = 1'b0;
                  if (idx_ff == LAST_IDX) begin
                     phase_in = (phase_ff == PH_SHELL) ? PH_BCAP : PH_BFAN;
                     idx_in   = (phase_ff == PH_SHELL) ? RING_W'(0) : RING_W'(1);
                  end else begin
                     idx_in = idx_ff + RING_W'(1);
                  end
               end
            end
            PH_BCAP, PH_TCAP: begin
               if (idx_ff == LAST_IDX) begin
                  phase_in = (phase_ff == PH_BCAP) ? PH_TCAP : PH_SHTRI;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + RING_W'(1);
               end
            end
            PH_BFAN: begin
               if (idx_ff == FAN_LAST) begin
                  phase_in = PH_TFAN;
                  idx_in   = RING_W'(1);
               end else begin
                  idx_in = idx_ff + RING_W'(1);
               end
            end
            PH_TFAN: begin
               idx_in = idx_ff + RING_W'(1);
            end
            default: begin
               active_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= PH_SHELL;
         idx_ff    <= '0;
         sub_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         sub_ff    <= sub_in;
      end
   end

   // Load the next cylinder's operands
   always_ff @(posedge clock) begin
      if (pop) begin
         radius_ff <= head_job.radius;
         h2_ff     <= head_job.half_height;
      end
   end

   // Decode the current step into a record descriptor
   always_comb begin
      i5     = CORNER_W'(idx_ff);
      j5     = (idx_ff == LAST_IDX) ? CORNER_W'(0) : i5 + CORNER_W'(1);
      d_kind = KIND_TRIANGLE;
      d_top  = 1'b0;
      d_nsel = NORM_NONE;
      d_ca   = '0;
      d_cb   = '0;
      d_cc   = '0;
      unique case (phase_ff)
         PH_SHELL: begin
            d_kind = KIND_VERTEX;
            d_top  = sub_ff;
            d_nsel = NORM_SHELL;
         end
         PH_BCAP: begin
            d_kind = KIND_VERTEX;
            d_nsel = NORM_BOT;
         end
         PH_TCAP: begin
            d_kind = KIND_VERTEX;
            d_top  = 1'b1;
            d_nsel = NORM_TOP;
         end
         PH_SHTRI: begin
            if (!sub_ff) begin
               d_ca = {i5[CORNER_W-2:0], 1'b0};
               d_cb = {j5[CORNER_W-2:0], 1'b0};
               d_cc = {j5[CORNER_W-2:0], 1'b1};
            end else begin
               d_ca = {j5[CORNER_W-2:0], 1'b1};
               d_cb = {i5[CORNER_W-2:0], 1'b1};
               d_cc = {i5[CORNER_W-2:0], 1'b0};
            end
         end
         PH_BFAN: begin
            d_ca = N5 + N5;
            d_cb = N5 + N5 + i5 + CORNER_W'(1);
            d_cc = N5 + N5 + i5;
         end
         PH_TFAN: begin
            d_ca = N5 + N5 + N5;
            d_cb = N5 + N5 + N5 + i5;
            d_cc = N5 + N5 + N5 + i5 + CORNER_W'(1);
         end
         default: begin
            d_kind = KIND_TRIANGLE;
         end
      endcase
   end

   // Look up trig values, multiply by radius, pick normals
   always_comb begin
      cos_sel = COS_TAB[TAB_ROW][idx_ff];
      sin_sel = SIN_TAB[TAB_ROW][idx_ff];
      r_s     = $signed({1'b0, radius_ff});
      px_full = r_s * cos_sel;
      py_full = r_s * sin_sel;
      nx_in   = '0;
      ny_in   = '0;
      nz_in   = '0;
      unique case (d_nsel)
         NORM_SHELL: begin
            nx_in = to_norm(cos_sel);
            ny_in = to_norm(sin_sel);
         end
         NORM_BOT:  nz_in = -NORM_UNIT;
         NORM_TOP:  nz_in = NORM_UNIT;
         NORM_NONE: nz_in = '0;
         default:   nz_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_kind_ff <= d_kind;
      b_last_ff <= seq_last;
      b_top_ff  <= d_top;
      b_ca_ff   <= d_ca;
      b_cb_ff   <= d_cb;
      b_cc_ff   <= d_cc;
      b_h2_ff   <= h2_ff;
      b_px_ff   <= px_full[63:0];
      b_py_ff   <= py_full[63:0];
      b_nx_ff   <= nx_in;
      b_ny_ff   <= ny_in;
      b_nz_ff   <= nz_in;
   end

   // Round and saturate positions, blank fields that carry no meaning
   always_comb begin
      rsp_in             = '0;
      rsp_in.record_kind = b_kind_ff;
      rsp_in.last_record = b_last_ff;
      if (b_kind_ff == KIND_VERTEX) begin
         rsp_in.pos_x  = round_sat(b_px_ff);
         rsp_in.pos_y  = round_sat(b_py_ff);
         rsp_in.pos_z  = b_top_ff ? $signed({1'b0, b_h2_ff})
                                  : 32'sd0 - $signed({1'b0, b_h2_ff});
         rsp_in.norm_x = b_nx_ff;
         rsp_in.norm_y = b_ny_ff;
         rsp_in.norm_z = b_nz_ff;
      end else begin
         rsp_in.corner_a = b_ca_ff;
         rsp_in.corner_b = b_cb_ff;
         rsp_in.corner_c = b_cc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/cmg_checker.sv @@
// Port-level checks on the result stream of the cylinder mesh generator.
// Depends on cmg_pkg; bound to cylinder_mesh_generator below.
module cmg_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input cmg_pkg::rsp_type rsp_data
);
   import cmg_pkg::*;

   // Records of one cylinder come without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_record |=> rsp_valid)
      else $error("gap inside a cylinder's record stream");

   // The final record of a cylinder is a triangle
   a_last_is_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_record |-> rsp_data.record_kind == KIND_TRIANGLE)
      else $error("last record is not a triangle");

   // Vertices never follow a triangle within one cylinder
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == KIND_TRIANGLE && !rsp_data.last_record
      |=> rsp_data.record_kind == KIND_TRIANGLE)
      else $error("vertex record after a triangle record");

   // Vertex records carry no corners
   a_vertex_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == KIND_VERTEX
      |-> rsp_data.corner_a == '0 && rsp_data.corner_b == '0 && rsp_data.corner_c == '0)
      else $error("vertex record with nonzero corners");

endmodule

bind cylinder_mesh_generator cmg_checker u_cmg_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
